[rtl/core/adsnp_pkg.sv]
// Package for the device-notification sample parser.
// Holds the position width, header byte counts, the parse phase and record kind codes,
// and the record and push types that the parser and its output queue share.
package adsnp_pkg;

    // Width of the byte position counter inside one block.
    localparam int unsigned POSITION_BITS = 16;

    // Width of the bounds-check arithmetic: a position plus a 32-bit size.
    localparam int unsigned CMP_BITS =
        ((POSITION_BITS + 1 > 32) ? POSITION_BITS + 1 : 32) + 1;

    // Header layout, in bytes.
    localparam int unsigned WORDS_BYTES      = 8;
    localparam int unsigned LEN_WORD_BYTES   = 4;
    localparam int unsigned STAMP_HDR_BYTES  = 12;
    localparam int unsigned STAMP_TIME_BYTES = 8;
    localparam int unsigned SAMPLE_HDR_BYTES = 8;

    // Output queue depth; the parser may push two records per transfer.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_BITS    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_WORDS   = 3'd0,
        PH_STAMP   = 3'd1,
        PH_SAMPLE  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_DONE    = 3'd4,
        PH_REJECT  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        REC_PAYLOAD  = 2'd0,
        REC_EMPTY    = 2'd1,
        REC_ACCEPTED = 2'd2,
        REC_REJECTED = 2'd3
    } record_kind_t;

    typedef struct packed {
        record_kind_t  record_kind;
        logic [31:0]   sample_handle;
        logic [15:0]   sample_size;
        logic [63:0]   stamp_time;
        logic [7:0]    payload_byte;
        logic [15:0]   payload_offset;
        logic          sample_last;
        logic          run_last;
    } rec_t;

    // Records produced by one accepted byte: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        rec_t       first;
        rec_t       second;
    } push_t;

endpackage

[rtl/core/adsnp_if.sv]
// Channel interfaces of the device-notification sample parser.
// Depends on adsnp_pkg for the record kind type.
interface adsnp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] block_length;
    logic        block_end;

    modport source (output valid, data_byte, block_length, block_end, input ready);
    modport sink   (input valid, data_byte, block_length, block_end, output ready);
endinterface

interface adsnp_out_if;
    logic                   valid;
    logic                   ready;
    adsnp_pkg::record_kind_t record_kind;
    logic [31:0]            sample_handle;
    logic [15:0]            sample_size;
    logic [63:0]            stamp_time;
    logic [7:0]             payload_byte;
    logic [15:0]            payload_offset;
    logic                   sample_last;
    logic                   run_last;

    modport source (output valid, record_kind, sample_handle, sample_size, stamp_time,
                    payload_byte, payload_offset, sample_last, run_last, input ready);
    modport sink   (input valid, record_kind, sample_handle, sample_size, stamp_time,
                    payload_byte, payload_offset, sample_last, run_last, output ready);
endinterface

[rtl/core/adsnp_outq.sv]
// Output record queue of the device-notification sample parser.
// Takes up to two records per cycle and hands them out one transfer at a time.
// Depends on adsnp_pkg and adsnp_out_if.
module adsnp_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  adsnp_pkg::push_t    push,
    output logic                has_room,
    adsnp_out_if.source         records
);

    adsnp_pkg::rec_t                 slot_reg [adsnp_pkg::QUEUE_DEPTH];
    logic [adsnp_pkg::PTR_BITS-1:0]  wr_ptr_reg;
    logic [adsnp_pkg::PTR_BITS-1:0]  wr_ptr_next;
    logic [adsnp_pkg::PTR_BITS-1:0]  wr_ptr_plus1;
    logic [adsnp_pkg::PTR_BITS-1:0]  rd_ptr_reg;
    logic [adsnp_pkg::PTR_BITS-1:0]  rd_ptr_next;
    logic [adsnp_pkg::PTR_BITS:0]    count_reg;
    logic [adsnp_pkg::PTR_BITS:0]    count_next;
    logic                            pop;
    adsnp_pkg::rec_t                 head;

    assign pop          = records.valid && records.ready;
    assign wr_ptr_plus1 = wr_ptr_reg + adsnp_pkg::PTR_BITS'(1);
    assign wr_ptr_next  = wr_ptr_reg + adsnp_pkg::PTR_BITS'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + adsnp_pkg::PTR_BITS'(pop);
    assign count_next   = count_reg + (adsnp_pkg::PTR_BITS+1)'(push.count)
                          - (adsnp_pkg::PTR_BITS+1)'(pop);

    // Room for the worst case of two records from the next transfer.
    assign has_room = count_reg <= (adsnp_pkg::PTR_BITS+1)'(adsnp_pkg::QUEUE_DEPTH - 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            slot_reg[wr_ptr_plus1] <= push.second;
        end
    end

    assign head                   = slot_reg[rd_ptr_reg];
    assign records.valid          = count_reg != '0;
    assign records.record_kind    = head.record_kind;
    assign records.sample_handle  = head.sample_handle;
    assign records.sample_size    = head.sample_size;
    assign records.stamp_time     = head.stamp_time;
    assign records.payload_byte   = head.payload_byte;
    assign records.payload_offset = head.payload_offset;
    assign records.sample_last    = head.sample_last;
    assign records.run_last       = head.run_last;

    // The queue never holds more records than it has slots.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (adsnp_pkg::PTR_BITS+1)'(adsnp_pkg::QUEUE_DEPTH))
        else $error("output queue overflow");

    // Pointers and occupancy move together.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        adsnp_pkg::PTR_BITS'(wr_ptr_reg - rd_ptr_reg) == adsnp_pkg::PTR_BITS'(count_reg))
        else $error("output queue pointers disagree with occupancy");

endmodule

[rtl/core/ads_notification_sample_parser.sv]
// Top level of the device-notification sample parser.
// Holds the parse state and the per-byte decode; depends on adsnp_pkg, adsnp_if
// and adsnp_outq.

// The block takes one byte of a notification block per transfer and can accept a byte
// in every clock cycle. Each byte is decoded combinationally against the parse state
// (headers, stamp and sample counts, bounds checks) and its records, at most two, go
// into a four-entry output queue that feeds the record channel one transfer per ready
// cycle. The input is ready while the queue has room for two records, so with an
// always-ready record sink the sustained rate is one byte per cycle; a byte that yields
// two records (a payload or empty-sample record on the block's final byte) needs an
// extra output transfer, and the queue absorbs it. A sample's payload bytes are
// released only after its header has shown that the whole payload fits inside the block
// length. The final byte of a block, marked by block_end, always yields an accepted or
// rejected status record and returns the parser to its reset state for the next block.
module ads_notification_sample_parser (
    input  logic        clk,
    input  logic        rst_n,
    adsnp_in_if.sink    items,
    adsnp_out_if.source records
);

    localparam int unsigned PB = adsnp_pkg::POSITION_BITS;
    localparam int unsigned CB = adsnp_pkg::CMP_BITS;

    // Parse state.
    logic [PB-1:0]         pos_reg,      pos_next;
    adsnp_pkg::phase_t     phase_reg,    phase_next;
    logic [3:0]            fcount_reg,   fcount_next;
    logic [63:0]           fshift_reg,   fshift_next;
    logic [31:0]           stamps_reg,   stamps_next;
    logic [31:0]           samples_reg,  samples_next;
    logic [63:0]           time_reg,     time_next;
    logic [31:0]           handle_reg,   handle_next;
    logic [15:0]           size_reg,     size_next;
    logic [15:0]           offset_reg,   offset_next;

    logic                  accept;
    logic                  has_room;
    adsnp_pkg::push_t      push;

    // Decode helpers.
    logic [PB:0]           pos_inc;
    logic [CB-1:0]         next_ext;
    logic [CB-1:0]         len_ext;
    logic                  header_phase;
    logic [3:0]            fcount_inc;
    logic [63:0]           shift_acc;
    logic                  stamp_fits;
    logic                  sample_fits;
    logic                  payload_fits;
    logic                  words_bad;
    logic                  payload_last;
    logic                  do_sample;
    logic                  do_stamp;
    logic                  have_rec;
    adsnp_pkg::rec_t       rec_a;
    adsnp_pkg::rec_t       rec_end;

    assign items.ready = has_room;
    assign accept      = items.valid && items.ready;

    assign pos_inc  = {1'b0, pos_reg} + (PB+1)'(1);
    assign next_ext = CB'(pos_inc);
    assign len_ext  = CB'(items.block_length);

    assign header_phase = (phase_reg == adsnp_pkg::PH_WORDS)
                       || (phase_reg == adsnp_pkg::PH_STAMP)
                       || (phase_reg == adsnp_pkg::PH_SAMPLE);
    assign fcount_inc = fcount_reg + 4'd1;
    // Little-endian gather: the byte lands in the lane picked by the low count bits.
    assign shift_acc  = fshift_reg | (64'(items.data_byte) << {fcount_reg[2:0], 3'b000});

    // Bounds checks, all against the block length carried with this byte.
    assign stamp_fits   = next_ext + CB'(adsnp_pkg::STAMP_HDR_BYTES) <= len_ext;
    assign sample_fits  = next_ext + CB'(adsnp_pkg::SAMPLE_HDR_BYTES) <= len_ext;
    assign payload_fits = next_ext + CB'(shift_acc[63:32]) <= len_ext;
    assign words_bad    = (len_ext < CB'(adsnp_pkg::WORDS_BYTES))
                       || (CB'(adsnp_pkg::LEN_WORD_BYTES) + CB'(shift_acc[31:0]) > len_ext);
    assign payload_last = ({1'b0, offset_reg} + 17'd1) >= {1'b0, size_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        fcount_next  = fcount_reg;
        fshift_next  = fshift_reg;
        stamps_next  = stamps_reg;
        samples_next = samples_reg;
        time_next    = time_reg;
        handle_next  = handle_reg;
        size_next    = size_reg;
        offset_next  = offset_reg;
        pos_next     = pos_reg;
        do_sample    = 1'b0;
        do_stamp     = 1'b0;
        have_rec     = 1'b0;
        rec_a        = '0;

        if (header_phase)
        begin
            fshift_next = shift_acc;
            fcount_next = fcount_inc;
        end

        unique case (phase_reg)
            adsnp_pkg::PH_WORDS:
            begin
                if (fcount_inc == 4'(adsnp_pkg::WORDS_BYTES))
                begin
                    stamps_next = shift_acc[63:32];
                    if (words_bad)
                    begin
                        phase_next  = adsnp_pkg::PH_REJECT;
                        fcount_next = '0;
                        fshift_next = '0;
                    end
                    else
                    begin
                        do_stamp = 1'b1;
                    end
                end
            end
            adsnp_pkg::PH_STAMP:
            begin
                if (fcount_inc == 4'(adsnp_pkg::STAMP_TIME_BYTES))
                begin
                    // The count word gathers into the low lanes after the timestamp.
                    time_next   = shift_acc;
                    fshift_next = '0;
                end
                else if (fcount_inc == 4'(adsnp_pkg::STAMP_HDR_BYTES))
                begin
                    samples_next = shift_acc[31:0];
                    do_sample    = 1'b1;
                end
            end
            adsnp_pkg::PH_SAMPLE:
            begin
                if (fcount_inc == 4'(adsnp_pkg::SAMPLE_HDR_BYTES))
                begin
                    handle_next = shift_acc[31:0];
                    if (!payload_fits)
                    begin
                        phase_next  = adsnp_pkg::PH_REJECT;
                        fcount_next = '0;
                        fshift_next = '0;
                    end
                    else
                    begin
                        size_next   = shift_acc[47:32];
                        offset_next = '0;
                        if (shift_acc[47:32] == 16'd0)
                        begin
                            have_rec                = 1'b1;
                            rec_a.record_kind       = adsnp_pkg::REC_EMPTY;
                            rec_a.sample_handle     = shift_acc[31:0];
                            rec_a.stamp_time        = time_reg;
                            rec_a.sample_last       = 1'b1;
                            do_sample               = 1'b1;
                        end
                        else
                        begin
                            phase_next  = adsnp_pkg::PH_PAYLOAD;
                            fcount_next = '0;
                            fshift_next = '0;
                        end
                    end
                end
            end
            adsnp_pkg::PH_PAYLOAD:
            begin
                have_rec             = 1'b1;
                rec_a.record_kind    = adsnp_pkg::REC_PAYLOAD;
                rec_a.sample_handle  = handle_reg;
                rec_a.sample_size    = size_reg;
                rec_a.stamp_time     = time_reg;
                rec_a.payload_byte   = items.data_byte;
                rec_a.payload_offset = offset_reg;
                rec_a.sample_last    = payload_last;
                offset_next          = offset_reg + 16'd1;
                do_sample            = payload_last;
            end
            default:
            begin
                // Done and rejected blocks ignore bytes until the block ends.
            end
        endcase

        // Move to the next sample, or to the next stamp when the samples run out.
        if (do_sample)
        begin
            if (samples_next == 32'd0)
            begin
                do_stamp = 1'b1;
            end
            else
            begin
                fcount_next = '0;
                fshift_next = '0;
                if (!sample_fits)
                begin
                    phase_next = adsnp_pkg::PH_REJECT;
                end
                else
                begin
                    samples_next = samples_next - 32'd1;
                    phase_next   = adsnp_pkg::PH_SAMPLE;
                end
            end
        end

        if (do_stamp)
        begin
            fcount_next = '0;
            fshift_next = '0;
            if (stamps_next == 32'd0)
            begin
                phase_next = adsnp_pkg::PH_DONE;
            end
            else if (!stamp_fits)
            begin
                phase_next = adsnp_pkg::PH_REJECT;
            end
            else
            begin
                stamps_next = stamps_next - 32'd1;
                phase_next  = adsnp_pkg::PH_STAMP;
            end
        end

        // Status record for the final byte; the block is accepted only if every stamp
        // has been parsed by the end of this byte.
        rec_end             = '0;
        rec_end.record_kind = (phase_next == adsnp_pkg::PH_DONE) ? adsnp_pkg::REC_ACCEPTED
                                                                 : adsnp_pkg::REC_REJECTED;
        rec_end.run_last    = 1'b1;

        if (items.block_end)
        begin
            phase_next   = adsnp_pkg::PH_WORDS;
            fcount_next  = '0;
            fshift_next  = '0;
            stamps_next  = '0;
            samples_next = '0;
            time_next    = '0;
            handle_next  = '0;
            size_next    = '0;
            offset_next  = '0;
            pos_next     = '0;
        end
        else
        begin
            // The position saturates at its all-ones value.
            pos_next = pos_inc[PB] ? {PB{1'b1}} : pos_inc[PB-1:0];
        end

        rec_a.run_last = !items.block_end;

        push = '0;
        if (accept)
        begin
            if (have_rec && items.block_end)
            begin
                push.count  = 2'd2;
                push.first  = rec_a;
                push.second = rec_end;
            end
            else if (have_rec)
            begin
                push.count = 2'd1;
                push.first = rec_a;
            end
            else if (items.block_end)
            begin
                push.count = 2'd1;
                push.first = rec_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= adsnp_pkg::PH_WORDS;
            fcount_reg  <= '0;
            fshift_reg  <= '0;
            stamps_reg  <= '0;
            samples_reg <= '0;
            time_reg    <= '0;
            handle_reg  <= '0;
            size_reg    <= '0;
            offset_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            fcount_reg  <= fcount_next;
            fshift_reg  <= fshift_next;
            stamps_reg  <= stamps_next;
            samples_reg <= samples_next;
            time_reg    <= time_next;
            handle_reg  <= handle_next;
            size_reg    <= size_next;
            offset_reg  <= offset_next;
        end
    end

    adsnp_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .has_room (has_room),
        .records  (records)
    );

    // The final byte of a block always leaves the parser at the start of a new block.
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && items.block_end |=> phase_reg == adsnp_pkg::PH_WORDS && pos_reg == '0)
        else $error("parser did not return to block start after block end");

    // While payload flows, the offset stays inside the announced sample size.
    a_offset_in_sample: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == adsnp_pkg::PH_PAYLOAD |-> offset_reg < size_reg)
        else $error("payload offset ran past the sample size");

    // In the words and sample phases, header gathering stays below eight bytes.
    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == adsnp_pkg::PH_WORDS || phase_reg == adsnp_pkg::PH_SAMPLE)
            |-> fcount_reg < 4'(adsnp_pkg::WORDS_BYTES))
        else $error("header byte count out of range");

    // No records appear without an accepted byte behind them.
    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> accept)
        else $error("records pushed without a transfer");

endmodule

[tb/tb_ads_notification_sample_parser.sv]
// Self-checking testbench for the device-notification sample parser.
// Depends on adsnp_pkg, the adsnp_in_if and adsnp_out_if channels and the parser RTL;
// it predicts every record from its own copy of the parse state and checks each transfer.

module tb_ads_notification_sample_parser;

    timeunit 1ns;
    timeprecision 1ps;

    // The run is stopped as failed if it ever gets this far.
    localparam int LIMIT_CYCLES = 400000;

    // Cycles to keep watching the record channel after the last expected record,
    // enough for the four-entry output queue to give up anything it still holds.
    localparam int TAIL_CYCLES = 16;

    // The byte position saturates at this value inside a block.
    localparam longint unsigned POS_MAX = (64'd1 << adsnp_pkg::POSITION_BITS) - 1;

    // How a generated block departs from a well-formed one.
    typedef enum int {
        FLAW_NONE,
        FLAW_LENGTH_WORD,
        FLAW_SHORT_BLOCK_LEN,
        FLAW_EXTRA_STAMPS,
        FLAW_SAMPLE_COUNT,
        FLAW_OVERSIZE,
        FLAW_EARLY_END,
        FLAW_LATE_END,
        FLAW_LENGTH_CHANGE,
        FLAW_LONG_BLOCK_LEN,
        FLAW_NOISE
    } flaw_t;

    // Stall patterns of the record receiver.
    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_LIGHT,
        RX_PERIODIC
    } rx_pattern_t;

    logic clk;
    logic rst_n;

    adsnp_in_if  byte_ch ();
    adsnp_out_if record_ch ();

    ads_notification_sample_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (byte_ch.sink),
        .records (record_ch.source)
    );

    // Records the parser owes us, oldest first.
    adsnp_pkg::rec_t expected_records[$];

    int fail_count  = 0;
    int bytes_sent  = 0;
    int cycle_count = 0;

    // Sender pacing: a burst of back-to-back bytes, then a random gap of up to
    // gap_max idle cycles. A gap_max of zero gives stretches with no idling.
    int burst_left = 0;
    int gap_max    = 0;

    // Receiver pacing. A test asks for a long hold-off through hold_request; the
    // receiver process takes it over and counts it down itself.
    int          hold_request = 0;
    int          hold_left    = 0;
    int          pattern_left = 0;
    int          rx_tick      = 0;
    rx_pattern_t rx_pattern   = RX_OPEN;

    // Our own copy of the parse state.
    longint unsigned   byte_pos;
    adsnp_pkg::phase_t phase_q;
    logic [3:0]        hdr_count;
    logic [63:0]       hdr_shift;
    logic [31:0]       stamps_todo;
    logic [31:0]       samples_todo;
    logic [63:0]       stamp_time_q;
    logic [31:0]       handle_q;
    logic [15:0]       size_q;
    logic [15:0]       offset_q;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void start_field(adsnp_pkg::phase_t next_phase);
        phase_q   = next_phase;
        hdr_count = '0;
        hdr_shift = '0;
    endfunction

    function automatic void reset_parser();
        byte_pos     = 0;
        start_field(adsnp_pkg::PH_WORDS);
        stamps_todo  = '0;
        samples_todo = '0;
        stamp_time_q = '0;
        handle_q     = '0;
        size_q       = '0;
        offset_q     = '0;
    endfunction

    // Move on to the next stamp header, or finish when all stamps are parsed.
    // A stamp header that would run past the block length rejects the block.
    function automatic void advance_stamp(longint unsigned start, longint unsigned blen);
        if (stamps_todo == 0)
            start_field(adsnp_pkg::PH_DONE);
        else if (start + 64'(adsnp_pkg::STAMP_HDR_BYTES) > blen)
            start_field(adsnp_pkg::PH_REJECT);
        else
        begin
            stamps_todo = stamps_todo - 1;
            start_field(adsnp_pkg::PH_STAMP);
        end
    endfunction

    // Same for the next sample header inside the current stamp.
    function automatic void advance_sample(longint unsigned start, longint unsigned blen);
        if (samples_todo == 0)
            advance_stamp(start, blen);
        else if (start + 64'(adsnp_pkg::SAMPLE_HDR_BYTES) > blen)
            start_field(adsnp_pkg::PH_REJECT);
        else
        begin
            samples_todo = samples_todo - 1;
            start_field(adsnp_pkg::PH_SAMPLE);
        end
    endfunction

    function automatic adsnp_pkg::rec_t make_record(adsnp_pkg::record_kind_t kind,
                                                    logic [31:0] handle,
                                                    logic [15:0] size, logic [63:0] stamp,
                                                    logic [7:0] data, logic [15:0] offset,
                                                    logic ends_sample);
        adsnp_pkg::rec_t r;
        r.record_kind    = kind;
        r.sample_handle  = handle;
        r.sample_size    = size;
        r.stamp_time     = stamp;
        r.payload_byte   = data;
        r.payload_offset = offset;
        r.sample_last    = ends_sample;
        r.run_last       = 1'b0;
        return r;
    endfunction

    // Advances the parse state by one accepted byte and queues the records that
    // byte must produce. The phase is decided once, on the state before the byte,
    // and block_end is applied after the byte itself has been parsed.
    function automatic void decode_byte(logic [7:0] data, logic [15:0] blen_in,
                                        logic ends_block);
        adsnp_pkg::rec_t produced[$];
        adsnp_pkg::rec_t r;
        longint unsigned nxt;
        longint unsigned blen;
        longint unsigned hdr_size;
        logic [15:0]     off;
        logic            ends_sample;

        nxt  = byte_pos + 1;
        blen = 64'(blen_in);

        if (phase_q == adsnp_pkg::PH_WORDS || phase_q == adsnp_pkg::PH_STAMP
            || phase_q == adsnp_pkg::PH_SAMPLE)
        begin
            hdr_shift = hdr_shift | (64'(data) << {hdr_count[2:0], 3'b000});
            hdr_count = hdr_count + 4'd1;
        end

        case (phase_q)
            adsnp_pkg::PH_WORDS:
            begin
                if (hdr_count == adsnp_pkg::WORDS_BYTES)
                begin
                    stamps_todo = hdr_shift[63:32];
                    if (blen < 64'(adsnp_pkg::WORDS_BYTES)
                        || 64'(adsnp_pkg::LEN_WORD_BYTES) + 64'(hdr_shift[31:0]) > blen)
                        start_field(adsnp_pkg::PH_REJECT);
                    else
                        advance_stamp(nxt, blen);
                end
            end
            adsnp_pkg::PH_STAMP:
            begin
                // The timestamp is taken after eight bytes; the sample count then
                // gathers from a cleared shift register.
                if (hdr_count == adsnp_pkg::STAMP_TIME_BYTES)
                begin
                    stamp_time_q = hdr_shift;
                    hdr_shift    = '0;
                end
                else if (hdr_count == adsnp_pkg::STAMP_HDR_BYTES)
                begin
                    samples_todo = hdr_shift[31:0];
                    advance_sample(nxt, blen);
                end
            end
            adsnp_pkg::PH_SAMPLE:
            begin
                if (hdr_count == adsnp_pkg::SAMPLE_HDR_BYTES)
                begin
                    hdr_size = 64'(hdr_shift[63:32]);
                    handle_q = hdr_shift[31:0];
                    // The whole payload must fit before any byte of it is released.
                    if (nxt + hdr_size > blen)
                        start_field(adsnp_pkg::PH_REJECT);
                    else
                    begin
                        size_q   = hdr_size[15:0];
                        offset_q = '0;
                        if (size_q == 0)
                        begin
                            produced.push_back(make_record(adsnp_pkg::REC_EMPTY, handle_q,
                                                           16'd0, stamp_time_q, 8'd0,
                                                           16'd0, 1'b1));
                            advance_sample(nxt, blen);
                        end
                        else
                            start_field(adsnp_pkg::PH_PAYLOAD);
                    end
                end
            end
            adsnp_pkg::PH_PAYLOAD:
            begin
                off         = offset_q;
                ends_sample = (32'(off) + 1 >= 32'(size_q));
                produced.push_back(make_record(adsnp_pkg::REC_PAYLOAD, handle_q, size_q,
                                               stamp_time_q, data, off, ends_sample));
                offset_q = off + 16'd1;
                if (ends_sample)
                    advance_sample(nxt, blen);
            end
            default:
            begin
                // Trailing bytes and bytes of a rejected block are ignored.
            end
        endcase

        if (ends_block)
        begin
            produced.push_back(make_record((phase_q == adsnp_pkg::PH_DONE)
                                               ? adsnp_pkg::REC_ACCEPTED
                                               : adsnp_pkg::REC_REJECTED,
                                           32'd0, 16'd0, 64'd0, 8'd0, 16'd0, 1'b0));
            reset_parser();
        end
        else
            byte_pos = (nxt > POS_MAX) ? POS_MAX : nxt;

        if (produced.size() > 0)
        begin
            r = produced.pop_back();
            r.run_last = 1'b1;
            produced.push_back(r);
        end
        foreach (produced[i])
            expected_records.push_back(produced[i]);
    endfunction

    // ------------------------------------------------------------------
    // Record receiver and checker
    // ------------------------------------------------------------------

    // The receiver switches between its stall patterns at random, so there are long
    // stretches where it never stalls and stretches where it stalls often. A requested
    // hold-off overrides the pattern while it lasts.
    initial
    begin
        record_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left       = hold_left - 1;
                record_ch.ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    rx_pattern   = rx_pattern_t'($urandom_range(RX_OPEN, RX_PERIODIC));
                    pattern_left = $urandom_range(16, 128);
                end
                pattern_left = pattern_left - 1;
                rx_tick      = rx_tick + 1;
                case (rx_pattern)
                    RX_OPEN:     record_ch.ready <= 1'b1;
                    RX_HALF:     record_ch.ready <= ($urandom_range(0, 1) == 1);
                    RX_LIGHT:    record_ch.ready <= ($urandom_range(0, 9) != 0);
                    default:     record_ch.ready <= ((rx_tick % 4) != 3);
                endcase
            end
        end
    end

    // Every record transfer is compared with the oldest expected record. The
    // values read here are those from before the edge, so the parser's own
    // updates at this edge cannot leak in.
    always @(posedge clk)
    begin : record_check
        adsnp_pkg::rec_t want;
        if (rst_n && record_ch.valid && record_ch.ready)
        begin
            if (expected_records.size() == 0)
            begin
                $error("unexpected record: kind %0d handle %h offset %0d",
                       record_ch.record_kind, record_ch.sample_handle,
                       record_ch.payload_offset);
                fail_count++;
            end
            else
            begin
                want = expected_records.pop_front();
                if (record_ch.record_kind !== want.record_kind)
                begin
                    $error("record_kind: expected %0d, got %0d",
                           want.record_kind, record_ch.record_kind);
                    fail_count++;
                end
                if (record_ch.sample_handle !== want.sample_handle)
                begin
                    $error("sample_handle: expected %h, got %h",
                           want.sample_handle, record_ch.sample_handle);
                    fail_count++;
                end
                if (record_ch.sample_size !== want.sample_size)
                begin
                    $error("sample_size: expected %0d, got %0d",
                           want.sample_size, record_ch.sample_size);
                    fail_count++;
                end
                if (record_ch.stamp_time !== want.stamp_time)
                begin
                    $error("stamp_time: expected %h, got %h",
                           want.stamp_time, record_ch.stamp_time);
                    fail_count++;
                end
                if (record_ch.payload_byte !== want.payload_byte)
                begin
                    $error("payload_byte: expected %h, got %h",
                           want.payload_byte, record_ch.payload_byte);
                    fail_count++;
                end
                if (record_ch.payload_offset !== want.payload_offset)
                begin
                    $error("payload_offset: expected %0d, got %0d",
                           want.payload_offset, record_ch.payload_offset);
                    fail_count++;
                end
                if (record_ch.sample_last !== want.sample_last)
                begin
                    $error("sample_last: expected %0b, got %0b",
                           want.sample_last, record_ch.sample_last);
                    fail_count++;
                end
                if (record_ch.run_last !== want.run_last)
                begin
                    $error("run_last: expected %0b, got %0b",
                           want.run_last, record_ch.run_last);
                    fail_count++;
                end
            end
        end
    end

    // A hung handshake ends the run here.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------

    // Offers one byte and returns at the edge where it transfers. Every path
    // to the next offer passes at least one edge, so valid is never lowered and
    // raised again within one time step.
    task automatic send_byte(logic [7:0] data, logic [15:0] blen, logic ends_block);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;

        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= data;
        byte_ch.block_length <= blen;
        byte_ch.block_end    <= ends_block;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);

        decode_byte(data, blen, ends_block);
        bytes_sent++;
    endtask

    // Sends a whole block, with block_end on its final byte. With vary_len set,
    // about one byte in eight carries a different block length.
    task automatic send_block(ref logic [7:0] blk[$], input logic [15:0] blen,
                              input bit vary_len);
        logic [15:0] this_len;
        for (int i = 0; i < blk.size(); i++)
        begin
            this_len = blen;
            if (vary_len && $urandom_range(0, 7) == 0)
                this_len = 16'($urandom_range(1, 65535));
            send_byte(blk[i], this_len, i == blk.size() - 1);
        end
    endtask

    // Stops offering bytes until every expected record has been taken.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        burst_left    = 0;
        @(posedge clk);
        while (expected_records.size() != 0)
            @(posedge clk);
    endtask

    function automatic void put_le(ref logic [7:0] q[$], input logic [63:0] v,
                                   input int nbytes);
        for (int i = 0; i < nbytes; i++)
            q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void patch_le(ref logic [7:0] q[$], input int at,
                                     input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            q[at + i] = v[8*i +: 8];
    endfunction

    // Builds a block with random stamps, samples and payload, spoils it as the
    // flaw asks and sends it. Positions of the sample-count and size words are
    // kept so that a flaw can hit them.
    task automatic send_random_block(flaw_t flaw);
        logic [7:0]  blk[$];
        int          count_at[$];
        int          size_at[$];
        int unsigned n_stamps;
        int unsigned n_samples;
        int unsigned sz;
        int unsigned span;
        int unsigned keep;
        int          at;
        int          pick;
        logic [15:0] blen;
        logic [31:0] len_word;
        logic [31:0] stamp_word;
        bit          vary_len;

        vary_len = 1'b0;

        if (flaw == FLAW_NOISE)
        begin
            repeat ($urandom_range(1, 40))
                blk.push_back(8'($urandom));
            blen = ($urandom_range(0, 1) == 0) ? 16'(blk.size())
                                               : 16'($urandom_range(1, 65535));
            send_block(blk, blen, $urandom_range(0, 3) == 0);
            return;
        end

        n_stamps = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
        put_le(blk, 64'd0, adsnp_pkg::WORDS_BYTES);
        for (int s = 0; s < n_stamps; s++)
        begin
            put_le(blk, {$urandom, $urandom}, adsnp_pkg::STAMP_TIME_BYTES);
            count_at.push_back(blk.size());
            n_samples = $urandom_range(0, 2);
            put_le(blk, 64'(n_samples), 4);
            for (int k = 0; k < n_samples; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    sz = 0;
                else if (pick < 9)
                    sz = $urandom_range(1, 5);
                else
                    sz = $urandom_range(6, 40);
                put_le(blk, 64'($urandom), 4);
                size_at.push_back(blk.size());
                put_le(blk, 64'(sz), 4);
                repeat (sz)
                    blk.push_back(8'($urandom));
            end
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                blk.push_back(8'($urandom));

        span       = blk.size();
        blen       = 16'(span);
        // The length word may claim less than the block holds, never more.
        len_word   = ($urandom_range(0, 1) == 0) ? span - 4 : $urandom_range(0, span - 4);
        stamp_word = n_stamps;

        case (flaw)
            FLAW_LENGTH_WORD:
                len_word = ($urandom_range(0, 1) == 0) ? span - 3
                                                       : 32'hFFFF_FFFF - $urandom_range(0, 15);
            FLAW_SHORT_BLOCK_LEN:
                blen = 16'($urandom_range(1, adsnp_pkg::WORDS_BYTES - 1));
            FLAW_EXTRA_STAMPS:
                stamp_word = ($urandom_range(0, 1) == 0) ? n_stamps + $urandom_range(1, 2)
                                                         : $urandom;
            FLAW_SAMPLE_COUNT:
                if (count_at.size() > 0)
                begin
                    at = count_at[$urandom_range(0, count_at.size() - 1)];
                    patch_le(blk, at, ($urandom_range(0, 1) == 0) ? $urandom_range(3, 5)
                                                                   : $urandom);
                end
            FLAW_OVERSIZE:
                if (size_at.size() > 0)
                begin
                    // Either one to four bytes past the end of the block, or far past it.
                    at   = size_at[$urandom_range(0, size_at.size() - 1)];
                    pick = $urandom_range(0, 2);
                    if (pick == 0)
                        patch_le(blk, at, span - (at + 4) + 1 + $urandom_range(0, 3));
                    else if (pick == 1)
                        patch_le(blk, at, 32'hFFFF_FFFF);
                    else
                        patch_le(blk, at, $urandom);
                end
            FLAW_LONG_BLOCK_LEN:
                blen = 16'($urandom_range(span, 65535));
            FLAW_LENGTH_CHANGE:
                vary_len = 1'b1;
            default:
            begin
            end
        endcase

        patch_le(blk, 0, len_word);
        patch_le(blk, adsnp_pkg::LEN_WORD_BYTES, stamp_word);

        // Ending the block early or late changes only where block_end falls.
        if (flaw == FLAW_EARLY_END && blk.size() > 1)
        begin
            keep = $urandom_range(1, blk.size() - 1);
            while (blk.size() > keep)
                void'(blk.pop_back());
        end
        else if (flaw == FLAW_LATE_END)
            repeat ($urandom_range(1, 6))
                blk.push_back(8'($urandom));

        send_block(blk, blen, vary_len);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short hand-built blocks at the edges: a block that ends on its first
    // byte, the smallest accepted block, a length word far beyond the largest
    // block length, and a block length too short to hold the opening words.
    task automatic test_edge_blocks();
        logic [7:0] blk[$];
        gap_max = 0;

        blk.push_back(8'hFF);
        send_block(blk, 16'd1, 1'b0);

        blk.delete();
        put_le(blk, 64'd4, adsnp_pkg::LEN_WORD_BYTES);
        put_le(blk, 64'd0, 4);
        send_block(blk, 16'd8, 1'b0);

        blk.delete();
        put_le(blk, 64'hFFFF_FFFF, adsnp_pkg::LEN_WORD_BYTES);
        put_le(blk, 64'd0, 4);
        send_block(blk, 16'hFFFF, 1'b0);

        blk.delete();
        put_le(blk, 64'd3, adsnp_pkg::LEN_WORD_BYTES);
        put_le(blk, 64'd0, 4);
        send_block(blk, 16'd7, 1'b0);
    endtask

    // Well-formed blocks with random content, under changing sender pacing.
    task automatic test_wellformed_blocks(int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            send_random_block(FLAW_NONE);
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // bytes back to back, so the output queue fills and the input stalls.
    task automatic test_stalled_output();
        gap_max      = 0;
        hold_request = 300;
        repeat (3)
            send_random_block(FLAW_NONE);
        wait_drained();
    endtask

    // Broken blocks of every kind, and noise, with a clean block now and then
    // so that the parser is seen to recover after each rejection.
    task automatic test_broken_blocks(int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            send_random_block(flaw_t'($urandom_range(FLAW_NONE, FLAW_NOISE)));
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = 8'd0;
        byte_ch.block_length = 16'd1;
        byte_ch.block_end    = 1'b0;
        reset_parser();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_blocks();
        wait_drained();
        test_wellformed_blocks(800);
        wait_drained();
        test_stalled_output();
        test_broken_blocks(450);
        wait_drained();

        // Any record that turns up now has no byte behind it and is flagged.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
